// ===== rtl/core/gbr_pkg.sv =====
// gbr_pkg: shared types and codes for the glyph line renderer.
// Used by gbr_search, gbr_rowgen and bitmap_glyph_line_renderer; no dependencies.
`timescale 1ns / 1ps
package gbr_pkg;

  localparam logic [1:0] CMD_LOAD_HDR  = 2'd0;
  localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
  localparam logic [1:0] CMD_RENDER    = 2'd2;
  localparam logic [1:0] CMD_UNUSED    = 2'd3;

  localparam logic [1:0] KIND_ROW      = 2'd0;
  localparam logic [1:0] KIND_MISSING  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  entry_index;
    logic [15:0] char_code;
    logic [5:0]  glyph_width_in;
    logic [5:0]  glyph_height_in;
    logic [11:0] bitmap_offset;
    logic [11:0] byte_address;
    logic [7:0]  bitmap_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] row_bits;
    logic [4:0]  row_number;
    logic [5:0]  glyph_width_out;
    logic [15:0] x_start;
    logic [15:0] line_width;
    logic [5:0]  line_height;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] code;
    logic [5:0]  w;
    logic [5:0]  h;
    logic [11:0] off;
  } hdr_t;

  typedef struct packed {
    logic [31:0] bits;
    logic [4:0]  number;
    logic        last;
  } row_t;

endpackage

// ===== rtl/core/gbr_search.sv =====
// gbr_search: glyph header table and iterative binary search over it.
// Depends on gbr_pkg.
`timescale 1ns / 1ps
module gbr_search #(
  parameter int MAX_GLYPHS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          we,
  input  logic [$clog2(MAX_GLYPHS)-1:0] widx,
  input  gbr_pkg::hdr_t                 wdata,
  input  logic                          start,
  input  logic [15:0]                   code,
  input  logic [8:0]                    count,
  output logic                          done,
  output logic                          found,
  output gbr_pkg::hdr_t                 hdr
);
  localparam int AW = $clog2(MAX_GLYPHS);
  localparam int CW = AW + 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  gbr_pkg::hdr_t table_mem [MAX_GLYPHS];
  gbr_pkg::hdr_t rdata;
  logic [1:0]    state;
  logic [CW-1:0] lo, hiex, mid;
  logic [15:0]   key;

  assign mid = lo + ((hiex - lo - CW'(1)) >> 1);
  assign hdr = rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[widx] <= wdata;
    end
    if (state == S_CHK && lo < hiex) begin
      rdata <= table_mem[mid[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      found <= 1'b0;
      lo    <= '0;
      hiex  <= '0;
      key   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            key   <= code;
            lo    <= '0;
            hiex  <= (32'(count) > MAX_GLYPHS) ? CW'(MAX_GLYPHS) : CW'(count);
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (lo >= hiex) begin
            done  <= 1'b1;
            found <= 1'b0;
            state <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata.code < key) begin
            done  <= 1'b0;
            lo    <= mid + CW'(1);
            state <= S_CHK;
          end else if (rdata.code > key) begin
            done  <= 1'b0;
            hiex  <= mid;
            state <= S_CHK;
          end else begin
            done  <= 1'b1;
            found <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/gbr_rowgen.sv =====
// gbr_rowgen: bitmap store and row assembly, one stored byte, or part of one, per step.
// Depends on gbr_pkg.
`timescale 1ns / 1ps
module gbr_rowgen #(
  parameter int BITMAP_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [$clog2(BITMAP_BYTES)-1:0] waddr,
  input  logic [7:0]                      wdata,
  input  logic                            start,
  input  gbr_pkg::hdr_t                   hdr,
  output logic                            row_valid,
  output gbr_pkg::row_t                   row,
  input  logic                            ack
);
  localparam int BW = $clog2(BITMAP_BYTES);
  localparam int PW = (BW + 1 > 12) ? BW + 1 : 12;
  localparam logic [2:0] R_IDLE  = 3'd0;
  localparam logic [2:0] R_RED   = 3'd1;
  localparam logic [2:0] R_FETCH = 3'd2;
  localparam logic [2:0] R_DATA  = 3'd3;
  localparam logic [2:0] R_EMIT  = 3'd4;

  logic [7:0]    store [BITMAP_BYTES];
  logic [7:0]    rdata, rev, chunk;
  logic [2:0]    state;
  logic [PW-1:0] ptr;
  logic [2:0]    s;
  logic [3:0]    t, room, left;
  logic [5:0]    w, h, i, j;
  logic [31:0]   acc;
  logic [8:0]    mask;

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    if (state == R_FETCH && i != w) begin
      rdata <= store[ptr[BW-1:0]];
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rev[k] = rdata[7-k];
    end
    room  = 4'd8 - 4'(s);
    left  = ((w - i) > 6'(room)) ? room : 4'(w - i);
    t     = left;
    mask  = (9'd1 << t) - 9'd1;
    chunk = (rev >> s) & mask[7:0];
  end

  assign row_valid  = (state == R_EMIT);
  assign row.bits   = acc;
  assign row.number = j[4:0];
  assign row.last   = (j + 6'd1 == h);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      ptr   <= '0;
      s     <= '0;
      w     <= '0;
      h     <= '0;
      i     <= '0;
      j     <= '0;
      acc   <= '0;
    end else begin
      case (state)
        R_IDLE: begin
          if (start) begin
            ptr   <= PW'(hdr.off);
            w     <= hdr.w;
            h     <= hdr.h;
            s     <= '0;
            i     <= '0;
            j     <= '0;
            acc   <= '0;
            state <= R_RED;
          end
        end
        R_RED: begin
          if (32'(ptr) >= BITMAP_BYTES) begin
            ptr <= ptr - PW'(BITMAP_BYTES);
          end else begin
            state <= R_FETCH;
          end
        end
        R_FETCH: begin
          state <= (i == w) ? R_EMIT : R_DATA;
        end
        R_DATA: begin
          acc <= acc | (32'(chunk) << i);
          i   <= i + 6'(t);
          if (4'(s) + t == 4'd8) begin
            s   <= '0;
            ptr <= (32'(ptr) == BITMAP_BYTES - 1) ? '0 : ptr + PW'(1);
          end else begin
            s <= s + 3'(t);
          end
          state <= R_FETCH;
        end
        R_EMIT: begin
          if (ack) begin
            j     <= j + 6'd1;
            i     <= '0;
            acc   <= '0;
            state <= row.last ? R_IDLE : R_FETCH;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/bitmap_glyph_line_renderer.sv =====
// bitmap_glyph_line_renderer: command sequencer, running line sums, result register.
// Depends on gbr_pkg, gbr_search and gbr_rowgen.
//
//  port group        dir  handshake         carries
//  in_*              in   valid / stall     gbr_pkg::in_t command transaction
//  out_*             out  valid / stall     gbr_pkg::out_t result transaction
//  cfg_*             in   valid / ready     glyph_count (9 bits)
//
// A render searches the header table by binary search, a check state and a compare
// state per probe, reduces the bitmap offset by repeated subtraction, then fetches
// the stored bytes of each row one chunk at a time and emits the row.
// Reset (rst, synchronous) clears control state and the line sums; stores stay undefined.
// Input is stalled while a render is in progress or a result sits in the output register.
`timescale 1ns / 1ps
module bitmap_glyph_line_renderer #(
  parameter int MAX_GLYPHS    = 256,
  parameter int BITMAP_BYTES  = 4096,
  parameter int MAX_GLYPH_DIM = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  gbr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gbr_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [8:0]    cfg_data
);
  localparam logic [1:0] T_IDLE   = 2'd0;
  localparam logic [1:0] T_SEARCH = 2'd1;
  localparam logic [1:0] T_ROWS   = 2'd2;

  logic [1:0]    state;
  logic [8:0]    glyph_count;
  logic [15:0]   running_width, xs;
  logic [5:0]    running_height;
  logic [16:0]   wsum;
  logic          accept, out_free, out_load;
  logic          hdr_we, byte_we, srch_start, srch_done, srch_found, rows_start;
  logic          row_valid, row_ack;
  gbr_pkg::hdr_t new_hdr, found_hdr;
  gbr_pkg::row_t row;
  gbr_pkg::out_t out_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != T_IDLE) || out_valid;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign hdr_we     = accept && in_data.cmd == gbr_pkg::CMD_LOAD_HDR
                      && 32'(in_data.entry_index) < MAX_GLYPHS;
  assign byte_we    = accept && in_data.cmd == gbr_pkg::CMD_LOAD_BYTE
                      && 32'(in_data.byte_address) < BITMAP_BYTES;
  assign srch_start = accept && in_data.cmd == gbr_pkg::CMD_RENDER
                      && in_data.char_code != 16'd0;
  assign rows_start = state == T_SEARCH && srch_done && srch_found
                      && found_hdr.h != 6'd0;
  assign row_ack    = state == T_ROWS && row_valid && out_free;
  assign wsum       = 17'(running_width) + 17'(found_hdr.w);

  always_comb begin
    new_hdr.code = in_data.char_code;
    new_hdr.w    = (32'(in_data.glyph_width_in) > MAX_GLYPH_DIM)
                   ? 6'(MAX_GLYPH_DIM) : in_data.glyph_width_in;
    new_hdr.h    = (32'(in_data.glyph_height_in) > MAX_GLYPH_DIM)
                   ? 6'(MAX_GLYPH_DIM) : in_data.glyph_height_in;
    new_hdr.off  = in_data.bitmap_offset;
  end

  // next result transaction
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    case (state)
      T_IDLE: begin
        if (accept && in_data.cmd == gbr_pkg::CMD_RENDER && in_data.char_code == 16'd0) begin
          out_load             = 1'b1;
          out_next.kind        = gbr_pkg::KIND_SUMMARY;
          out_next.line_width  = running_width;
          out_next.line_height = running_height;
          out_next.last        = 1'b1;
        end
      end
      T_SEARCH: begin
        if (srch_done && !srch_found) begin
          out_load      = 1'b1;
          out_next.kind = gbr_pkg::KIND_MISSING;
          out_next.last = 1'b1;
        end
      end
      T_ROWS: begin
        if (row_ack) begin
          out_load                 = 1'b1;
          out_next.kind            = gbr_pkg::KIND_ROW;
          out_next.row_bits        = row.bits;
          out_next.row_number      = row.number;
          out_next.glyph_width_out = found_hdr.w;
          out_next.x_start         = xs;
          out_next.last            = row.last;
        end
      end
      default: ;
    endcase
  end

  gbr_search #(.MAX_GLYPHS(MAX_GLYPHS)) u_search (
    .clk   (clk),
    .rst   (rst),
    .we    (hdr_we),
    .widx  ($clog2(MAX_GLYPHS)'(in_data.entry_index)),
    .wdata (new_hdr),
    .start (srch_start),
    .code  (in_data.char_code),
    .count (glyph_count),
    .done  (srch_done),
    .found (srch_found),
    .hdr   (found_hdr)
  );

  gbr_rowgen #(.BITMAP_BYTES(BITMAP_BYTES)) u_rowgen (
    .clk       (clk),
    .rst       (rst),
    .we        (byte_we),
    .waddr     ($clog2(BITMAP_BYTES)'(in_data.byte_address)),
    .wdata     (in_data.bitmap_byte),
    .start     (rows_start),
    .hdr       (found_hdr),
    .row_valid (row_valid),
    .row       (row),
    .ack       (row_ack)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      glyph_count    <= '0;
      running_width  <= '0;
      running_height <= '0;
      xs             <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        glyph_count <= cfg_data;
      end
      if (out_load) begin
        out_data  <= out_next;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept && in_data.cmd == gbr_pkg::CMD_RENDER) begin
            if (in_data.char_code == 16'd0) begin
              running_width  <= '0;
              running_height <= '0;
            end else begin
              state <= T_SEARCH;
            end
          end
        end
        T_SEARCH: begin
          if (srch_done) begin
            if (!srch_found) begin
              state <= T_IDLE;
            end else begin
              xs            <= running_width;
              running_width <= wsum[16] ? 16'hFFFF : wsum[15:0];
              if (found_hdr.h > running_height) begin
                running_height <= found_hdr.h;
              end
              state <= (found_hdr.h == 6'd0) ? T_IDLE : T_ROWS;
            end
          end
        end
        T_ROWS: begin
          if (row_ack && row.last) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/bitmap_glyph_line_renderer_checker.sv =====
// Checker for bitmap_glyph_line_renderer: watches the command, result and register
// channels, predicts every result and compares them field by field. Depends on gbr_pkg.
`timescale 1ns / 1ps
module bitmap_glyph_line_renderer_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_stall,
  input  gbr_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  gbr_pkg::out_t out_data,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [8:0]    cfg_data,
  output int            fails,
  output int            pending
);
  localparam int GLYPHS = 256;
  localparam int BYTES  = 4096;
  localparam int DIM    = 32;

  gbr_pkg::hdr_t font[GLYPHS];
  logic [7:0]    pixels[BYTES];
  int unsigned   line_w;
  logic [5:0]    line_h;
  logic [8:0]    glyph_count;
  gbr_pkg::out_t rows_due[$];

  initial begin
    fails   = 0;
    pending = 0;
  end

  function automatic logic [5:0] clip_dim(input logic [5:0] d);
    return (d > DIM) ? 6'(DIM) : d;
  endfunction

  task automatic predict_render(input gbr_pkg::in_t t);
    gbr_pkg::out_t r;
    gbr_pkg::hdr_t g;
    int            lo, hi, mid, hit;
    int unsigned   n, a;
    r = '0;
    if (t.char_code == 16'd0) begin
      r.kind = gbr_pkg::KIND_SUMMARY;
      r.line_width = 16'(line_w);
      r.line_height = line_h;
      r.last = 1'b1;
      rows_due.push_back(r);
      line_w = 0;
      line_h = '0;
      return;
    end
    lo = 0;
    hi = ((glyph_count > GLYPHS) ? GLYPHS : int'(glyph_count)) - 1;
    hit = -1;
    while (lo <= hi && hit < 0) begin
      mid = lo + (hi - lo) / 2;
      if (font[mid].code < t.char_code) lo = mid + 1;
      else if (font[mid].code > t.char_code) hi = mid - 1;
      else hit = mid;
    end
    if (hit < 0) begin
      r.kind = gbr_pkg::KIND_MISSING;
      r.last = 1'b1;
      rows_due.push_back(r);
      return;
    end
    g = font[hit];
    for (int j = 0; j < g.h; j++) begin
      r = '0;
      r.kind = gbr_pkg::KIND_ROW;
      r.row_number = 5'(j);
      r.glyph_width_out = g.w;
      r.x_start = 16'(line_w);
      r.last = (j + 1 == g.h);
      for (int i = 0; i < g.w; i++) begin
        n = j * g.w + i;
        a = (g.off + (n >> 3)) % BYTES;
        r.row_bits[i] = pixels[a][7 - (n & 7)];
      end
      rows_due.push_back(r);
    end
    line_w = line_w + g.w;
    if (line_w > 65535) line_w = 65535;
    if (g.h > line_h) line_h = g.h;
  endtask

  task automatic compare_row(input gbr_pkg::out_t got);
    gbr_pkg::out_t want;
    if (rows_due.size() == 0) begin
      $error("unexpected result transaction kind=%0d", got.kind);
      fails++;
      return;
    end
    want = rows_due.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind); fails++;
    end
    if (got.row_bits !== want.row_bits) begin
      $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits); fails++;
    end
    if (got.row_number !== want.row_number) begin
      $error("row_number: expected %0d, got %0d", want.row_number, got.row_number); fails++;
    end
    if (got.glyph_width_out !== want.glyph_width_out) begin
      $error("glyph_width_out: expected %0d, got %0d", want.glyph_width_out,
             got.glyph_width_out); fails++;
    end
    if (got.x_start !== want.x_start) begin
      $error("x_start: expected %0d, got %0d", want.x_start, got.x_start); fails++;
    end
    if (got.line_width !== want.line_width) begin
      $error("line_width: expected %0d, got %0d", want.line_width, got.line_width); fails++;
    end
    if (got.line_height !== want.line_height) begin
      $error("line_height: expected %0d, got %0d", want.line_height, got.line_height);
      fails++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last); fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_w = 0;
      line_h = '0;
      glyph_count = '0;
      rows_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) glyph_count = cfg_data;
      if (out_valid && !out_stall) compare_row(out_data);
      if (in_valid && !in_stall) begin
        case (in_data.cmd)
          gbr_pkg::CMD_LOAD_HDR:
            font[in_data.entry_index] = '{in_data.char_code, clip_dim(in_data.glyph_width_in),
                                          clip_dim(in_data.glyph_height_in),
                                          in_data.bitmap_offset};
          gbr_pkg::CMD_LOAD_BYTE: pixels[in_data.byte_address] = in_data.bitmap_byte;
          gbr_pkg::CMD_RENDER:    predict_render(in_data);
          default: ;
        endcase
      end
    end
    pending = rows_due.size();
  end
endmodule

// ===== tb/sv/bitmap_glyph_line_renderer_test.sv =====
// Top of the glyph line renderer testbench: clock, reset, command and register stimulus,
// result back-pressure and verdict. Depends on gbr_pkg, the block and its checker.
`timescale 1ns / 1ps
module bitmap_glyph_line_renderer_test;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  gbr_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  gbr_pkg::out_t out_data;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [8:0]    cfg_data;
  int            fails;
  int            pending;

  int          send_idle;
  int          recv_idle;
  logic        hold_off;
  logic [15:0] slot_code[256];
  logic [8:0]  count_now;

  bitmap_glyph_line_renderer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  bitmap_glyph_line_renderer_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle);
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic gbr_pkg::in_t noise_item();
    gbr_pkg::in_t t;
    t.cmd             = 2'($urandom);
    t.entry_index     = 8'($urandom);
    t.char_code       = 16'($urandom);
    t.glyph_width_in  = 6'($urandom);
    t.glyph_height_in = 6'($urandom);
    t.bitmap_offset   = 12'($urandom);
    t.byte_address    = 12'($urandom);
    t.bitmap_byte     = 8'($urandom);
    return t;
  endfunction

  task automatic send(input gbr_pkg::in_t t);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_glyph(input int slot, input logic [15:0] code, input logic [5:0] w,
                            input logic [5:0] h, input logic [11:0] off);
    gbr_pkg::in_t t;
    t = noise_item();
    t.cmd = gbr_pkg::CMD_LOAD_HDR;
    t.entry_index = 8'(slot);
    t.char_code = code;
    t.glyph_width_in = w;
    t.glyph_height_in = h;
    t.bitmap_offset = off;
    slot_code[slot] = code;
    send(t);
  endtask

  task automatic load_byte(input logic [11:0] a, input logic [7:0] b);
    gbr_pkg::in_t t;
    t = noise_item();
    t.cmd = gbr_pkg::CMD_LOAD_BYTE;
    t.byte_address = a;
    t.bitmap_byte = b;
    send(t);
  endtask

  task automatic render(input logic [15:0] code);
    gbr_pkg::in_t t;
    t = noise_item();
    t.cmd = gbr_pkg::CMD_RENDER;
    t.char_code = code;
    send(t);
  endtask

  task automatic unused_item();
    gbr_pkg::in_t t;
    t = noise_item();
    t.cmd = gbr_pkg::CMD_UNUSED;
    send(t);
  endtask

  function automatic logic [5:0] pick_width();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 12));
  endfunction

  function automatic logic [5:0] pick_height();
    return ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 6));
  endfunction

  // shape whose bits stay inside the preloaded low bytes
  task automatic pick_shape(output logic [5:0] w, output logic [5:0] h,
                            output logic [11:0] off);
    int wc, hc, span;
    w = pick_width();
    h = pick_height();
    wc = (w > 32) ? 32 : int'(w);
    hc = (h > 32) ? 32 : int'(h);
    span = (wc * hc + 7) / 8;
    off = 12'($urandom_range(0, 128 - span));
  endtask

  // sorted codes with fixed extremes at the ends of the table
  task automatic build_font();
    int          code;
    logic [5:0]  w, h;
    logic [11:0] off;
    code = $urandom_range(10, 100);
    for (int s = 3; s < 255; s++) begin
      pick_shape(w, h, off);
      load_glyph(s, 16'(code), w, h, off);
      code += $urandom_range(1, 250);
    end
    load_glyph(0, 16'd1, 6'd63, 6'd63, 12'd4095);
    load_glyph(1, 16'd2, 6'd32, 6'd0, 12'd0);
    load_glyph(2, 16'd3, 6'd0, 6'd5, 12'd17);
    load_glyph(255, 16'hFFFF, 6'd7, 6'd2, 12'd4094);
  endtask

  task automatic set_count(input logic [8:0] n);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    count_now = n;
  endtask

  task automatic long_hold();
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  endtask

  task automatic random_items(input int n);
    int          pick, lim, slot;
    logic [5:0]  w, h;
    logic [11:0] off;
    lim = (count_now > 256) ? 256 : int'(count_now);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60 && lim > 0) render(slot_code[$urandom_range(0, lim - 1)]);
      else if (pick < 70) render(16'($urandom));
      else if (pick < 78) render(16'd0);
      else if (pick < 90) load_byte(12'($urandom), 8'($urandom));
      else if (pick < 95) begin
        // keep code and order, change shape
        slot = $urandom_range(3, 254);
        pick_shape(w, h, off);
        load_glyph(slot, slot_code[slot], w, h, off);
      end else begin
        unused_item();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_off = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    count_now = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (int a = 0; a < 128; a++) load_byte(12'(a), 8'($urandom));
    load_byte(12'd4094, 8'($urandom));
    load_byte(12'd4095, 8'($urandom));
    build_font();
    set_count(9'd256);

    render(16'd1);
    render(16'd2);
    render(16'd3);
    render(16'hFFFF);
    render(16'd4);
    unused_item();
    render(16'd0);
    render(16'd0);
    set_count(9'd0);
    render(16'd1);
    render(16'd0);
    set_count(9'd511);
    render(16'hFFFF);
    render(16'd1);
    render(16'd0);
    set_count(9'd1);
    render(16'd1);
    render(16'd2);
    render(16'd0);

    send_idle = 32;
    recv_idle = 66;
    set_count(9'd256);
    random_items(6);
    fork
      long_hold();
    join_none
    random_items(6);
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    send_idle = 66;
    recv_idle = 32;
    set_count(9'($urandom_range(2, 255)));
    random_items(6);
    set_count(9'd511);
    random_items(6);

    send_idle = 0;
    recv_idle = 0;
    set_count(9'd256);
    random_items(8);
    render(16'd0);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(negedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
